// ----- sv/bft_pkg.sv -----
// Shared types and constants of the bus frame transceiver framer.
package bft_pkg;

   // Request function codes
   typedef enum logic [1:0] {
      FUNC_HEADER  = 2'd0,
      FUNC_PAYLOAD = 2'd1,
      FUNC_END     = 2'd2
   } func_type;

   // Kind of work handed from the front end to the serialiser
   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_PAIR   = 2'd1,
      KIND_END    = 2'd2
   } kind_type;

   localparam int          HDR_PAIRS     = 5;
   localparam int          PAIR_IDX_W    = $clog2(HDR_PAIRS);
   localparam int          STEP_W        = $clog2(2 * HDR_PAIRS);
   localparam logic [STEP_W-1:0] HDR_LAST_STEP  = STEP_W'(2 * HDR_PAIRS - 1);
   localparam logic [STEP_W-1:0] PAIR_LAST_STEP = STEP_W'(1);
   localparam int          POS_W         = 6;
   localparam logic [7:0]  CTRL_BASE     = 8'h90;
   localparam logic [7:0]  END_CODE      = 8'h40;
   localparam int          QUEUE_DEPTH   = 2;

   // One queued job: up to five frame bytes to send as indexed pairs
   typedef struct packed {
      kind_type                        kind;
      logic [POS_W-1:0]                pos;
      logic                            flag;
      logic [HDR_PAIRS-1:0][7:0]       data;
   } entry_type;

endpackage

// ----- sv/bft_front.sv -----
// Front end: takes requests, keeps the frame state and queues send jobs.
module bft_front #(
   parameter int MAX_POSITION = 63
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [1:0]           func,
   input  logic [15:0]          dest_address,
   input  logic [1:0]           priority_req,
   input  logic [7:0]           data_byte,
   input  logic                 csr_write,
   input  logic [15:0]          csr_data,
   output logic                 push,
   output bft_pkg::entry_type   push_entry
);

   localparam logic [bft_pkg::POS_W-1:0] MaxPos = bft_pkg::POS_W'(MAX_POSITION);

   logic [bft_pkg::POS_W-1:0] position_ff, position_in;
   logic [7:0]                check_ff, check_in;
   logic                      dropped_ff, dropped_in;
   logic [15:0]               host_address_ff;
   logic [7:0]                ctrl_byte;

   // Hold the own address
   always_ff @(posedge clock) begin
      if (reset) begin
         host_address_ff <= '0;
      end else if (csr_write) begin
         host_address_ff <= csr_data;
      end
   end

   assign ctrl_byte = bft_pkg::CTRL_BASE | {4'd0, priority_req, 2'd0};

   // Classify the request and advance the frame state
   always_comb begin
      position_in = position_ff;
      check_in    = check_ff;
      dropped_in  = dropped_ff;
      push        = 1'b0;
      push_entry  = '0;
      if (accept) begin
         unique case (bft_pkg::func_type'(func))
            bft_pkg::FUNC_HEADER: begin
               push            = 1'b1;
               push_entry.kind = bft_pkg::KIND_HEADER;
               push_entry.pos  = '0;
               push_entry.flag = 1'b0;
               push_entry.data = {dest_address[7:0], dest_address[15:8],
                                  host_address_ff[7:0], host_address_ff[15:8],
                                  ctrl_byte};
               position_in     = bft_pkg::POS_W'(bft_pkg::HDR_PAIRS);
               check_in        = ctrl_byte ^ host_address_ff[15:8] ^ host_address_ff[7:0]
                                 ^ dest_address[15:8] ^ dest_address[7:0];
               dropped_in      = 1'b0;
            end
            bft_pkg::FUNC_PAYLOAD: begin
               if (position_ff < MaxPos) begin
                  push               = 1'b1;
                  push_entry.kind    = bft_pkg::KIND_PAIR;
                  push_entry.pos     = position_ff;
                  push_entry.flag    = dropped_ff;
                  push_entry.data[0] = data_byte;
                  position_in        = position_ff + 1'b1;
                  check_in           = check_ff ^ data_byte;
               end else begin
                  dropped_in = 1'b1;
               end
            end
            bft_pkg::FUNC_END: begin
               push               = 1'b1;
               push_entry.kind    = bft_pkg::KIND_END;
               push_entry.pos     = position_ff;
               push_entry.flag    = dropped_ff;
               push_entry.data[0] = ~check_ff;
               position_in        = '0;
               check_in           = '0;
               dropped_in         = 1'b0;
            end
            default: begin
               // unused code: drop the request
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         check_ff    <= '0;
         dropped_ff  <= 1'b0;
      end else begin
         position_ff <= position_in;
         check_ff    <= check_in;
         dropped_ff  <= dropped_in;
      end
   end

endmodule

// ----- sv/bft_queue.sv -----
// Short job queue between the front end and the serialiser.
module bft_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bft_pkg::entry_type   push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output bft_pkg::entry_type   head
);

   localparam int PtrW = $clog2(bft_pkg::QUEUE_DEPTH);
   localparam int CntW = $clog2(bft_pkg::QUEUE_DEPTH + 1);

   bft_pkg::entry_type mem_ff [bft_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]    count_ff;

   assign full  = (count_ff == CntW'(bft_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(bft_pkg::QUEUE_DEPTH - 1)) ? '0
                         : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(bft_pkg::QUEUE_DEPTH - 1)) ? '0
                         : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- sv/bft_back.sv -----
// Back end: serialises queued jobs into transceiver bytes, one per cycle while the receiver does not stall.
module bft_back #(
   parameter logic [7:0] START_CODE = 8'd128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 empty,
   input  bft_pkg::entry_type   head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_tx_byte,
   output logic                 rsp_run_last,
   output logic                 rsp_overflow
);

   logic [bft_pkg::STEP_W-1:0]     step_ff, step_in;
   logic                           valid_ff, valid_in;
   logic [7:0]                     byte_ff, byte_in;
   logic                           last_ff, last_in;
   logic                           ovf_ff;
   logic                           load, fire;
   logic [bft_pkg::PAIR_IDX_W-1:0] idx;
   logic [bft_pkg::POS_W-1:0]      code_pos;

   assign load = !valid_ff || !rsp_stall;
   assign fire = load && !empty;
   assign idx  = step_ff[bft_pkg::STEP_W-1:1];
   assign code_pos = head.pos + bft_pkg::POS_W'(idx);

   // Pick the byte for the current step
   always_comb begin
      last_in = (head.kind == bft_pkg::KIND_HEADER) ? (step_ff == bft_pkg::HDR_LAST_STEP)
                                                    : (step_ff == bft_pkg::PAIR_LAST_STEP);
      if (step_ff[0]) begin
         byte_in = head.data[idx];
      end else if (head.kind == bft_pkg::KIND_END) begin
         byte_in = bft_pkg::END_CODE | {2'd0, head.pos};
      end else begin
         byte_in = START_CODE | {2'd0, code_pos};
      end
      valid_in = load ? !empty : valid_ff;
      step_in  = step_ff;
      if (fire) begin
         step_in = last_in ? '0 : step_ff + 1'b1;
      end
   end

   assign pop = fire && last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (fire) begin
         byte_ff <= byte_in;
         last_ff <= last_in;
         ovf_ff  <= head.flag;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_tx_byte  = byte_ff;
   assign rsp_run_last = last_ff;
   assign rsp_overflow = ovf_ff;

endmodule

// ----- sv/bus_frame_transceiver_framer.sv -----
// Bus frame transceiver framer: accepts one request per cycle while its two-entry job queue
// has room, and the back-end serialiser sends one byte per cycle while the receiver does not
// stall; a payload request gives two bytes, an end request two and a header request ten, so
// the serialiser sets the sustained rate. A request's first byte passes the queue, then the output register.
// Write host_address only while idle.
module bus_frame_transceiver_framer #(
   parameter logic [7:0] START_CODE   = 8'd128,
   parameter int         MAX_POSITION = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_dest_address,
   input  logic [1:0]  req_priority_req,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_run_last,
   output logic        rsp_overflow,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic               full, empty, push, pop;
   bft_pkg::entry_type push_entry, head;

   assign req_stall = full;
   assign csr_ready = 1'b1;

   // Classify requests
   bft_front #(
      .MAX_POSITION(MAX_POSITION)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_valid && !full),
      .func         (req_func),
      .dest_address (req_dest_address),
      .priority_req (req_priority_req),
      .data_byte    (req_data_byte),
      .csr_write    (csr_valid && csr_ready),
      .csr_data     (csr_data),
      .push         (push),
      .push_entry   (push_entry)
   );

   // Decouple front and back
   bft_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .empty      (empty),
      .head       (head)
   );

   // Serialise bytes
   bft_back #(
      .START_CODE(START_CODE)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .empty        (empty),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_tx_byte  (rsp_tx_byte),
      .rsp_run_last (rsp_run_last),
      .rsp_overflow (rsp_overflow)
   );

endmodule

// ----- sim/frame_stream_checker.sv -----
// Checker for the framer: predicts the transceiver byte stream and compares every response.
module frame_stream_checker #(
   parameter logic [7:0] START_CODE   = 8'd128,
   parameter int         MAX_POSITION = 63
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_dest_address,
   input  logic [1:0]  req_priority_req,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_tx_byte,
   input  logic        rsp_run_last,
   input  logic        rsp_overflow,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] tx;
      logic       last;
      logic       ovf;
   } tx_beat_type;

   // Bytes still owed by the block, oldest first
   tx_beat_type tx_expected[$];

   // Shadow of the framing state and the host address register
   logic [15:0] host_addr;
   logic [5:0]  fr_pos;
   logic [7:0]  fr_check;
   logic        fr_dropped;
   int          mismatch_count = 0;

   assign fail_count = mismatch_count;

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatch_count++;
      $display("%0t ns: framer response %s: got %02h, wanted %02h",
               $time, what, got, want);
   endtask

   // Queue one byte, tagged with the current drop flag
   task automatic push_beat(input logic [7:0] value);
      tx_beat_type beat;
      beat.tx   = value;
      beat.last = 1'b0;
      beat.ovf  = fr_dropped;
      tx_expected.push_back(beat);
   endtask

   // Queue an indexed pair and fold the frame byte into the check
   task automatic push_pair(input logic [7:0] frame_byte);
      push_beat(START_CODE | {2'b00, fr_pos});
      push_beat(frame_byte);
      fr_check = fr_check ^ frame_byte;
      fr_pos   = fr_pos + 6'd1;
   endtask

   // Work out the transmit bytes that one request causes
   task automatic build_frame_bytes(input logic [1:0] func, input logic [15:0] dest,
                                    input logic [1:0] prio, input logic [7:0] data);
      int          depth_before;
      tx_beat_type tail;
      depth_before = tx_expected.size();
      case (func)
         bft_pkg::FUNC_HEADER: begin
            fr_pos     = '0;
            fr_check   = '0;
            fr_dropped = 1'b0;
            push_pair(bft_pkg::CTRL_BASE | {4'b0000, prio, 2'b00});
            push_pair(host_addr[15:8]);
            push_pair(host_addr[7:0]);
            push_pair(dest[15:8]);
            push_pair(dest[7:0]);
         end
         bft_pkg::FUNC_PAYLOAD: begin
            if (int'(fr_pos) < MAX_POSITION) push_pair(data);
            else fr_dropped = 1'b1;
         end
         bft_pkg::FUNC_END: begin
            push_beat(bft_pkg::END_CODE | {2'b00, fr_pos});
            push_beat(~fr_check);
            fr_pos     = '0;
            fr_check   = '0;
            fr_dropped = 1'b0;
         end
         default: ;
      endcase
      // Mark the final byte of this request
      if (tx_expected.size() > depth_before) begin
         tail      = tx_expected.pop_back();
         tail.last = 1'b1;
         tx_expected.push_back(tail);
      end
   endtask

   // Predict on accepted requests, compare on accepted responses
   always @(posedge clock) begin
      tx_beat_type want;
      if (reset) begin
         tx_expected.delete();
         host_addr  = '0;
         fr_pos     = '0;
         fr_check   = '0;
         fr_dropped = 1'b0;
      end else begin
         if (csr_valid && csr_ready) host_addr = csr_data;
         if (req_valid && !req_stall)
            build_frame_bytes(req_func, req_dest_address, req_priority_req, req_data_byte);
         if (rsp_valid && !rsp_stall) begin
            if (tx_expected.size() == 0) begin
               report_mismatch("with nothing pending, tx_byte", rsp_tx_byte, 8'h00);
            end else begin
               want = tx_expected.pop_front();
               if (rsp_tx_byte !== want.tx)
                  report_mismatch("tx_byte", rsp_tx_byte, want.tx);
               if (rsp_run_last !== want.last)
                  report_mismatch("run_last", {7'b0, rsp_run_last}, {7'b0, want.last});
               if (rsp_overflow !== want.ovf)
                  report_mismatch("overflow", {7'b0, rsp_overflow}, {7'b0, want.ovf});
            end
         end
      end
      pending_count <= tx_expected.size();
   end

endmodule

// ----- sim/bus_frame_transceiver_framer_tb.sv -----
// Testbench top for the framer: drives requests, register writes and back-pressure, gives the verdict.
module bus_frame_transceiver_framer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] START_CODE_VAL = 8'd128;
   localparam int         MAX_POS        = 63;
   localparam logic [1:0] FUNC_SPARE     = 2'd3;
   localparam int         IDLE_PCT       = 27;
   localparam int         HOLD_CYCLES    = 80;
   localparam int         SETTLE_CYCLES  = 12;
   localparam int         RANDOM_ITEMS   = 95;
   localparam int         TIMEOUT_NS     = 5_000_000;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func         = bft_pkg::FUNC_HEADER;
   logic [15:0] req_dest_address = '0;
   logic [1:0]  req_priority_req = '0;
   logic [7:0]  req_data_byte    = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_run_last;
   logic        rsp_overflow;
   logic        csr_valid        = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data         = '0;

   int          fail_count;
   int          pending_count;
   int          items_sent       = 0;
   bit          quiet            = 1'b0;
   bit          hold_trigger     = 1'b0;

   always #5 clock = ~clock;

   bus_frame_transceiver_framer #(
      .START_CODE   (START_CODE_VAL),
      .MAX_POSITION (MAX_POS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_dest_address (req_dest_address),
      .req_priority_req (req_priority_req),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_overflow     (rsp_overflow),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   frame_stream_checker #(
      .START_CODE   (START_CODE_VAL),
      .MAX_POSITION (MAX_POS)
   ) checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_dest_address (req_dest_address),
      .req_priority_req (req_priority_req),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_overflow     (rsp_overflow),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   // Receiver: stall at random, or hold off for a long stretch when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_trigger) begin
            hold_trigger = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // Offer one request, with random idle cycles ahead of it, and wait for acceptance
   task automatic offer_request(input logic [1:0] func, input logic [15:0] dest,
                                input logic [1:0] prio, input logic [7:0] data);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_dest_address <= dest;
      req_priority_req <= prio;
      req_data_byte    <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // Drop valid, wait until every owed byte has come out, then let the block settle
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the host address while the block is idle
   task automatic write_host(input logic [15:0] value);
      drain_responses();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Header, payload bytes with the odd unused code mixed in, then end of frame
   task automatic send_random_frame(input int n_pay);
      offer_request(bft_pkg::FUNC_HEADER, 16'($urandom), 2'($urandom), 8'($urandom));
      for (int i = 0; i < n_pay; i++) begin
         if ($urandom_range(99) < 5)
            offer_request(FUNC_SPARE, 16'($urandom), 2'($urandom), 8'($urandom));
         offer_request(bft_pkg::FUNC_PAYLOAD, 16'($urandom), 2'($urandom), 8'($urandom));
      end
      offer_request(bft_pkg::FUNC_END, 16'($urandom), 2'($urandom), 8'($urandom));
   endtask

   // Stimulus and verdict
   initial begin
      int frames;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: headerless payload and end straight out of reset, unused code
      write_host(16'hFFFF);
      offer_request(bft_pkg::FUNC_PAYLOAD, 16'h0000, 2'd0, 8'hFF);
      offer_request(bft_pkg::FUNC_END,     16'h0000, 2'd0, 8'h00);
      offer_request(FUNC_SPARE,            16'hFFFF, 2'd3, 8'hFF);
      // Full frame at the field extremes, unused code mid-frame
      offer_request(bft_pkg::FUNC_HEADER,  16'hFFFF, 2'd3, 8'h00);
      offer_request(bft_pkg::FUNC_PAYLOAD, 16'h0000, 2'd0, 8'h00);
      offer_request(bft_pkg::FUNC_PAYLOAD, 16'hFFFF, 2'd3, 8'hFF);
      offer_request(FUNC_SPARE,            16'h0000, 2'd0, 8'h00);
      offer_request(bft_pkg::FUNC_PAYLOAD, 16'h5A5A, 2'd1, 8'hA5);
      offer_request(bft_pkg::FUNC_END,     16'hFFFF, 2'd3, 8'hFF);
      // Short frames at priorities 0, 1 and 2, one of them with a payload
      offer_request(bft_pkg::FUNC_HEADER,  16'h0000, 2'd0, 8'hFF);
      offer_request(bft_pkg::FUNC_END,     16'h0000, 2'd0, 8'h00);
      offer_request(bft_pkg::FUNC_HEADER,  16'h8001, 2'd1, 8'h00);
      offer_request(bft_pkg::FUNC_PAYLOAD, 16'h0000, 2'd0, 8'h5A);
      offer_request(bft_pkg::FUNC_END,     16'h0000, 2'd0, 8'h00);
      offer_request(bft_pkg::FUNC_HEADER,  16'h7FFE, 2'd2, 8'h00);
      offer_request(bft_pkg::FUNC_END,     16'h0000, 2'd0, 8'h00);
      // Restart a frame with a second header before its end
      write_host(16'h0000);
      offer_request(bft_pkg::FUNC_HEADER,  16'h1234, 2'd2, 8'h00);
      offer_request(bft_pkg::FUNC_PAYLOAD, 16'h0000, 2'd0, 8'h3C);
      offer_request(bft_pkg::FUNC_HEADER,  16'hFEDC, 2'd1, 8'h00);
      offer_request(bft_pkg::FUNC_END,     16'h0000, 2'd0, 8'h00);

      // Random: mostly well-formed short frames, some stray requests
      for (frames = 0; items_sent < RANDOM_ITEMS; frames++) begin
         if (frames % 10 == 9) write_host(16'($urandom));
         quiet = (frames >= 3 && frames < 9);
         if ($urandom_range(99) < 85)
            send_random_frame($urandom_range(0, 6));
         else
            offer_request(2'($urandom_range(0, 3)), 16'($urandom), 2'($urandom),
                          8'($urandom));
      end
      quiet = 1'b0;

      // Fill the frame past its last position while the receiver holds off
      write_host(16'($urandom));
      hold_trigger = 1'b1;
      send_random_frame(MAX_POS - 3);
      // Leave a frame open, restart it, then append headerless requests
      offer_request(bft_pkg::FUNC_HEADER, 16'($urandom), 2'($urandom), 8'($urandom));
      for (int i = 0; i < 3; i++)
         offer_request(bft_pkg::FUNC_PAYLOAD, 16'($urandom), 2'($urandom), 8'($urandom));
      offer_request(bft_pkg::FUNC_HEADER,  16'($urandom), 2'($urandom), 8'($urandom));
      offer_request(bft_pkg::FUNC_END,     16'($urandom), 2'($urandom), 8'($urandom));
      offer_request(bft_pkg::FUNC_PAYLOAD, 16'($urandom), 2'($urandom), 8'($urandom));
      offer_request(bft_pkg::FUNC_END,     16'($urandom), 2'($urandom), 8'($urandom));

      drain_responses();
      if (fail_count == 0)
         $display("bus_frame_transceiver_framer: match");
      else
         $display("bus_frame_transceiver_framer: mismatch");
      $finish;
   end

   // Guard against a hang
   initial begin
      #(TIMEOUT_NS);
      $display("bus_frame_transceiver_framer: mismatch");
      $finish;
   end

endmodule
